// ===== rtl/core/nsrtc_pkg.sv =====
// Shared types and constants for the nibble-serial real-time clock command port.
`default_nettype none

package nsrtc_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Bank register values
  localparam logic [7:0] CMD_BANK    = 8'h0B;
  localparam logic [7:0] STATUS_BANK = 8'h0D;

  // Read return values
  localparam logic [7:0] RD_UNMAPPED = 8'hFF;
  localparam logic [7:0] RD_STATUS   = 8'h01;
  localparam logic [7:0] RD_NONE     = 8'h00;

  // Command nibbles (high nibble of the write data)
  localparam logic [3:0] CMD_LATCH    = 4'h1;
  localparam logic [3:0] CMD_SHIFT_IN = 4'h3;
  localparam logic [3:0] CMD_MODE     = 4'h4;
  localparam logic [3:0] CMD_READ_SEL = 4'h6;

  // Arguments of the mode command
  localparam logic [3:0] ARG_POS_CLR  = 4'h0;
  localparam logic [3:0] ARG_WRITE    = 4'h3;
  localparam logic [3:0] ARG_READ     = 4'h7;

  // Access modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Clock limits
  localparam logic [5:0]  SEC_LAST     = 6'd59;
  localparam logic [10:0] MIN_LAST     = 11'd1439;
  localparam logic [11:0] MIN_PER_DAY  = 12'd1440;
  localparam logic [11:0] MIN_TWO_DAYS = 12'd2880;

  // Nibble positions
  localparam logic [2:0] POS_LAST_RD  = 3'd6;
  localparam logic [2:0] POS_WR_DONE  = 3'd6;

  // One request on the input channel
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] bank_select;
    logic [7:0] data;
  } nsrtc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/nsrtc_engine.sv =====
// Clock state, command decode and read mux of the RTC command port.
`default_nettype none

module nsrtc_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire nsrtc_pkg::nsrtc_item_t item,
  output logic [7:0]               read_data_nxt
);

  logic [5:0]  second_count_r, second_count_nxt;
  logic [10:0] minute_of_day_r, minute_of_day_nxt;
  logic [15:0] day_count_r, day_count_nxt;
  logic [27:0] latched_time_r, latched_time_nxt;
  logic [3:0]  out_nibble_r, out_nibble_nxt;
  logic [2:0]  nibble_pos_r, nibble_pos_nxt;
  logic [23:0] write_accum_r, write_accum_nxt;
  logic [1:0]  access_mode_r, access_mode_nxt;

  logic [3:0]  cmd;
  logic [3:0]  arg;
  logic [27:0] latch_val;
  logic [23:0] accum_base;
  logic [23:0] accum_new;
  logic [2:0]  pos_inc;
  logic [11:0] min_raw;
  logic [11:0] min_mod;

  assign cmd       = item.data[7:4];
  assign arg       = item.data[3:0];
  assign latch_val = {day_count_r, 1'b0, minute_of_day_r};
  assign pos_inc   = nibble_pos_r + 3'd1;

  // Shift-in accumulator: cleared at position 0, argument placed at its nibble
  assign accum_base = (nibble_pos_r == 3'd0) ? 24'd0 : write_accum_r;
  assign accum_new  = accum_base | ({20'd0, arg} << {nibble_pos_r, 2'b00});

  // Minute of day from the low 12 bits, reduced mod 1440 (value stays below 3*1440)
  assign min_raw = accum_new[11:0];
  always_comb begin
    if (min_raw >= nsrtc_pkg::MIN_TWO_DAYS) begin
      min_mod = min_raw - nsrtc_pkg::MIN_TWO_DAYS;
    end else if (min_raw >= nsrtc_pkg::MIN_PER_DAY) begin
      min_mod = min_raw - nsrtc_pkg::MIN_PER_DAY;
    end else begin
      min_mod = min_raw;
    end
  end

  // Next state and read result for the current request
  always_comb begin
    second_count_nxt  = second_count_r;
    minute_of_day_nxt = minute_of_day_r;
    day_count_nxt     = day_count_r;
    latched_time_nxt  = latched_time_r;
    out_nibble_nxt    = out_nibble_r;
    nibble_pos_nxt    = nibble_pos_r;
    write_accum_nxt   = write_accum_r;
    access_mode_nxt   = access_mode_r;
    read_data_nxt     = nsrtc_pkg::RD_NONE;

    unique case (item.func)
      nsrtc_pkg::FUNC_TICK: begin
        if (second_count_r >= nsrtc_pkg::SEC_LAST) begin
          second_count_nxt = 6'd0;
          if (minute_of_day_r >= nsrtc_pkg::MIN_LAST) begin
            minute_of_day_nxt = 11'd0;
            day_count_nxt     = day_count_r + 16'd1;
          end else begin
            minute_of_day_nxt = minute_of_day_r + 11'd1;
          end
        end else begin
          second_count_nxt = second_count_r + 6'd1;
        end
      end
      nsrtc_pkg::FUNC_READ: begin
        if (item.bank_select < nsrtc_pkg::CMD_BANK ||
            item.bank_select > nsrtc_pkg::STATUS_BANK) begin
          read_data_nxt = nsrtc_pkg::RD_UNMAPPED;
        end else if (item.bank_select == nsrtc_pkg::STATUS_BANK) begin
          read_data_nxt = nsrtc_pkg::RD_STATUS;
        end else begin
          read_data_nxt = {4'd0, out_nibble_r};
        end
      end
      nsrtc_pkg::FUNC_WRITE: begin
        if (item.bank_select == nsrtc_pkg::CMD_BANK) begin
          unique case (cmd)
            nsrtc_pkg::CMD_LATCH: begin
              latched_time_nxt = latch_val;
              if (access_mode_r == nsrtc_pkg::MODE_READ) begin
                out_nibble_nxt = 4'(latch_val >> {nibble_pos_r, 2'b00});
                nibble_pos_nxt = (nibble_pos_r >= nsrtc_pkg::POS_LAST_RD) ? 3'd0 : pos_inc;
              end
            end
            nsrtc_pkg::CMD_SHIFT_IN: begin
              if (access_mode_r == nsrtc_pkg::MODE_WRITE &&
                  nibble_pos_r < nsrtc_pkg::POS_WR_DONE) begin
                write_accum_nxt = accum_new;
                nibble_pos_nxt  = pos_inc;
                if (pos_inc == nsrtc_pkg::POS_WR_DONE) begin
                  minute_of_day_nxt = min_mod[10:0];
                  day_count_nxt     = {4'd0, accum_new[23:12]};
                  second_count_nxt  = 6'd0;
                  access_mode_nxt   = nsrtc_pkg::MODE_READ;
                end
              end
            end
            nsrtc_pkg::CMD_MODE: begin
              if (arg == nsrtc_pkg::ARG_POS_CLR) begin
                nibble_pos_nxt = 3'd0;
              end else if (arg == nsrtc_pkg::ARG_WRITE) begin
                access_mode_nxt = nsrtc_pkg::MODE_WRITE;
                nibble_pos_nxt  = 3'd0;
              end else if (arg == nsrtc_pkg::ARG_READ) begin
                access_mode_nxt = nsrtc_pkg::MODE_READ;
                nibble_pos_nxt  = 3'd0;
              end
            end
            nsrtc_pkg::CMD_READ_SEL: begin
              access_mode_nxt = nsrtc_pkg::MODE_READ;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per request that moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_count_r  <= 6'd0;
      minute_of_day_r <= 11'd0;
      day_count_r     <= 16'd0;
      latched_time_r  <= 28'd0;
      out_nibble_r    <= 4'd0;
      nibble_pos_r    <= 3'd0;
      write_accum_r   <= 24'd0;
      access_mode_r   <= nsrtc_pkg::MODE_NONE;
    end else if (fire) begin
      second_count_r  <= second_count_nxt;
      minute_of_day_r <= minute_of_day_nxt;
      day_count_r     <= day_count_nxt;
      latched_time_r  <= latched_time_nxt;
      out_nibble_r    <= out_nibble_nxt;
      nibble_pos_r    <= nibble_pos_nxt;
      write_accum_r   <= write_accum_nxt;
      access_mode_r   <= access_mode_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nibble_serial_rtc_command_port_core.sv =====
// Top level of the nibble-serial real-time clock command port.
//
// Usage: each input request is a one-second tick (func 0), a bus read
// (func 1) or a bus write (func 2) with its bank register value and data
// byte. Every request yields exactly one result on the out_ channel: the
// read byte for a bus read, zero otherwise. Both channels use valid/stall;
// a request moves when valid is high and stall is low.
// An accepted request passes the input register, then the result register,
// before out_valid. One request per cycle while out_stall is low; the clock
// state is updated by single-pass logic between the two registers.
// When out_stall holds a result, one more request can still be accepted
// into the input register; in_stall rises only once both registers hold
// work and the result is stalled. A stalled result does not change.
// Reset (rst_n low, synchronous) empties both registers and returns the
// clock to second 0, minute 0, day 0 with no access mode selected.
`default_nettype none

module nibble_serial_rtc_command_port_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_bank_select,
  input  wire logic [7:0] in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data
);

  logic                   in_vld_r;
  nsrtc_pkg::nsrtc_item_t item_r;
  logic                   out_vld_r;
  logic [7:0]             read_data_r;
  logic [7:0]             read_data_nxt;
  logic                   adv;
  logic                   take;

  // Input register advances when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.func        <= in_func;
      item_r.bank_select <= in_bank_select;
      item_r.data        <= in_data;
    end
  end

  nsrtc_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (adv),
    .item          (item_r),
    .read_data_nxt (read_data_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data_r <= read_data_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = read_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/nsrtc_checker.sv =====
// Port-level checks for the RTC command port, bound to its top level.
`default_nettype none

module nsrtc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_read_data
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)))
    else $error("stalled result changed");

  // Results are a nibble, the status value or the unmapped value
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data == 8'hFF || out_read_data[7:4] == 4'h0))
    else $error("result byte out of range");

endmodule

bind nibble_serial_rtc_command_port_core nsrtc_checker u_nsrtc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);

`default_nettype wire
